// ----- design/assert_macros.svh -----
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/fibp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fibp_pkg
// Shared constants, register codes and width helpers of the block permute.
// ----------------------------------------------------------------------------
package fibp_pkg;

   localparam int ELEMENT_W          = 64;
   localparam int ADDR_W             = 20;
   localparam int SIZE_W             = 6;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 6;
   localparam int DEFAULT_MAX_EXTENT = 32;
   localparam int QUEUE_DEPTH        = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SIZE_A      = 3'd0,
      REG_SIZE_B      = 3'd1,
      REG_SIZE_C      = 3'd2,
      REG_SIZE_D      = 3'd3,
      REG_SWAP_FIRST  = 3'd4,
      REG_SWAP_SECOND = 3'd5,
      REG_SWAP_HALVES = 3'd6
   } reg_index_type;

   // bits of one index counter
   function automatic int idx_width(input int max_extent);
      return (max_extent > 1) ? $clog2(max_extent) : 1;
   endfunction

   // bits of an effective extent, 1..max_extent
   function automatic int ext_width(input int max_extent);
      return $clog2(max_extent + 1);
   endfunction

   // element, last flag, four permuted indexes, three trailing target extents
   function automatic int entry_width(input int max_extent);
      return ELEMENT_W + 1 + 4 * idx_width(max_extent) + 3 * ext_width(max_extent);
   endfunction

endpackage
`default_nettype wire

// ----- design/four_index_block_permute.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_index_block_permute
// Streams the elements of a four-index block in source row-major order and
// tags each with its row-major address in the permuted target block.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 64-bit element per item, in source order (fourth index
//            fastest). accepted when req_valid is high and req_stall is low.
//   rsp_*  : the element unchanged, its 20-bit target address and a flag on
//            the last element of the block; taken when rsp_valid is high and
//            rsp_stall is low.
//   csr_*  : register writes (extents, swap flags), one per cycle when
//            csr_we is high. any write to a known register restarts the block
//            at index zero; write only while no item is in flight.
// Timing:
//   an accepted item passes the queue, then the s1, s2 and result registers.
//   one item per cycle sustained when nothing stalls, set by the three
//   multiply-add stages that fold the index tuple into the address.
// Stalls:
//   a stalled result freezes the pipeline; the front keeps accepting into a
//   two-entry queue and raises req_stall once it fills.
// Reset:
//   extents return to one, swap flags clear, counters and queue empty.
// ----------------------------------------------------------------------------
module four_index_block_permute #(
   parameter int MAX_EXTENT = fibp_pkg::DEFAULT_MAX_EXTENT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [fibp_pkg::ELEMENT_W-1:0]     req_element,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [fibp_pkg::ELEMENT_W-1:0]          rsp_element_out,
   output logic [fibp_pkg::ADDR_W-1:0]             rsp_target_address,
   output logic                                    rsp_block_end,
   input  wire logic                               csr_we,
   input  wire logic [fibp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [fibp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int ENTRY_W = fibp_pkg::entry_width(MAX_EXTENT);

   logic               push_valid;
   logic [ENTRY_W-1:0] push_data;
   logic               queue_full;
   logic               queue_pop;
   logic               queue_valid;
   logic [ENTRY_W-1:0] queue_data;

   fibp_front #(
      .MAX_EXTENT (MAX_EXTENT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_element (req_element),
      .req_stall   (req_stall),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_data   (push_data)
   );

   fibp_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (fibp_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_valid  (queue_valid),
      .pop_data   (queue_data)
   );

   fibp_back #(
      .MAX_EXTENT (MAX_EXTENT)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_valid        (queue_valid),
      .queue_data         (queue_data),
      .queue_pop          (queue_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_element_out    (rsp_element_out),
      .rsp_target_address (rsp_target_address),
      .rsp_block_end      (rsp_block_end)
   );

endmodule
`default_nettype wire

// ----- design/fibp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fibp_front
// Holds the registers and source index counters, accepts items and tags each
// with its permuted index tuple, target extents and end-of-block flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fibp_front #(
   parameter int MAX_EXTENT = fibp_pkg::DEFAULT_MAX_EXTENT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_valid,
   input  wire logic [fibp_pkg::ELEMENT_W-1:0]              req_element,
   output logic                                             req_stall,
   input  wire logic                                        csr_we,
   input  wire logic [fibp_pkg::CSR_INDEX_W-1:0]            csr_index,
   input  wire logic [fibp_pkg::CSR_DATA_W-1:0]             csr_wdata,
   input  wire logic                                        queue_full,
   output logic                                             push_valid,
   output logic [fibp_pkg::entry_width(MAX_EXTENT)-1:0]     push_data
);

   localparam int IDX_W = fibp_pkg::idx_width(MAX_EXTENT);
   localparam int EXT_W = fibp_pkg::ext_width(MAX_EXTENT);

   typedef struct packed {
      logic [fibp_pkg::ELEMENT_W-1:0] element;
      logic                           last;
      logic [3:0][IDX_W-1:0]          idx;
      logic [2:0][EXT_W-1:0]          dim;
   } entry_type;

   logic [fibp_pkg::SIZE_W-1:0] size_ff [4];
   logic [fibp_pkg::SIZE_W-1:0] size_in [4];
   logic                        swap_first_ff, swap_first_in;
   logic                        swap_second_ff, swap_second_in;
   logic                        swap_halves_ff, swap_halves_in;
   logic [IDX_W-1:0]            idx_ff [4];
   logic [IDX_W-1:0]            idx_in [4];

   logic [EXT_W-1:0] dim [4];
   logic [3:0]       last;
   logic [1:0]       ord [4];
   logic [1:0]       ord_tmp;
   logic             accept;
   logic             reg_hit;
   entry_type        entry;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push_valid = accept;
   assign push_data  = entry;

   // effective extents, zero reads as one and oversize clamps
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (size_ff[k] == '0) begin
            dim[k] = EXT_W'(1);
         end else if (32'(size_ff[k]) > 32'(MAX_EXTENT)) begin
            dim[k] = EXT_W'(MAX_EXTENT);
         end else begin
            dim[k] = EXT_W'(size_ff[k]);
         end
         last[k] = (32'(idx_ff[k]) + 32'd1) >= 32'(dim[k]);
      end
   end

   // target order of the source indexes
   always_comb begin
      ord[0] = swap_halves_ff ? 2'd2 : 2'd0;
      ord[1] = swap_halves_ff ? 2'd3 : 2'd1;
      ord[2] = swap_halves_ff ? 2'd0 : 2'd2;
      ord[3] = swap_halves_ff ? 2'd1 : 2'd3;
      ord_tmp = ord[0];
      if (swap_first_ff) begin
         ord[0] = ord[1];
         ord[1] = ord_tmp;
      end
      ord_tmp = ord[2];
      if (swap_second_ff) begin
         ord[2] = ord[3];
         ord[3] = ord_tmp;
      end
   end

   always_comb begin
      entry.element = req_element;
      entry.last    = &last;
      for (int k = 0; k < 4; k++) begin
         entry.idx[k] = idx_ff[ord[k]];
      end
      for (int k = 0; k < 3; k++) begin
         entry.dim[k] = dim[ord[k+1]];
      end
   end

   always_comb begin
      size_in        = size_ff;
      swap_first_in  = swap_first_ff;
      swap_second_in = swap_second_ff;
      swap_halves_in = swap_halves_ff;
      idx_in         = idx_ff;
      reg_hit        = 1'b0;
      if (csr_we) begin
         reg_hit = 1'b1;
         unique case (fibp_pkg::reg_index_type'(csr_index))
            fibp_pkg::REG_SIZE_A:      size_in[0]     = csr_wdata;
            fibp_pkg::REG_SIZE_B:      size_in[1]     = csr_wdata;
            fibp_pkg::REG_SIZE_C:      size_in[2]     = csr_wdata;
            fibp_pkg::REG_SIZE_D:      size_in[3]     = csr_wdata;
            fibp_pkg::REG_SWAP_FIRST:  swap_first_in  = csr_wdata[0];
            fibp_pkg::REG_SWAP_SECOND: swap_second_in = csr_wdata[0];
            fibp_pkg::REG_SWAP_HALVES: swap_halves_in = csr_wdata[0];
            default:                   reg_hit        = 1'b0;
         endcase
      end
      if (reg_hit) begin
         for (int k = 0; k < 4; k++) begin
            idx_in[k] = '0;
         end
      end else if (accept) begin
         // fourth index runs fastest, carries ripple toward the first
         idx_in[3] = last[3] ? '0 : idx_ff[3] + 1'b1;
         if (last[3]) begin
            idx_in[2] = last[2] ? '0 : idx_ff[2] + 1'b1;
            if (last[2]) begin
               idx_in[1] = last[1] ? '0 : idx_ff[1] + 1'b1;
               if (last[1]) begin
                  idx_in[0] = last[0] ? '0 : idx_ff[0] + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 4; k++) begin
            size_ff[k] <= fibp_pkg::SIZE_W'(1);
            idx_ff[k]  <= '0;
         end
         swap_first_ff  <= 1'b0;
         swap_second_ff <= 1'b0;
         swap_halves_ff <= 1'b0;
      end else begin
         size_ff        <= size_in;
         swap_first_ff  <= swap_first_in;
         swap_second_ff <= swap_second_in;
         swap_halves_ff <= swap_halves_in;
         idx_ff         <= idx_in;
      end
   end

   `ASSERT_NEXT(a_wrap_after_last, clock, reset, accept && entry.last,
      idx_ff[0] == '0 && idx_ff[1] == '0 && idx_ff[2] == '0 && idx_ff[3] == '0,
      "counters did not wrap after the last item of the block")

endmodule
`default_nettype wire

// ----- design/fibp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fibp_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fibp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = fibp_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH),
      "queue count above depth")
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, count_ff != '0,
      "pop from an empty queue")

endmodule
`default_nettype wire

// ----- design/fibp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fibp_back
// Three-stage multiply-add pipeline that folds the permuted index tuple into
// the row-major target address, ending in the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module fibp_back #(
   parameter int MAX_EXTENT = fibp_pkg::DEFAULT_MAX_EXTENT
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        queue_valid,
   input  wire logic [fibp_pkg::entry_width(MAX_EXTENT)-1:0] queue_data,
   output logic                                             queue_pop,
   output logic                                             rsp_valid,
   input  wire logic                                        rsp_stall,
   output logic [fibp_pkg::ELEMENT_W-1:0]                   rsp_element_out,
   output logic [fibp_pkg::ADDR_W-1:0]                      rsp_target_address,
   output logic                                             rsp_block_end
);

   localparam int IDX_W  = fibp_pkg::idx_width(MAX_EXTENT);
   localparam int EXT_W  = fibp_pkg::ext_width(MAX_EXTENT);
   localparam int ADDR_W = fibp_pkg::ADDR_W;

   typedef struct packed {
      logic [fibp_pkg::ELEMENT_W-1:0] element;
      logic                           last;
      logic [3:0][IDX_W-1:0]          idx;
      logic [2:0][EXT_W-1:0]          dim;
   } entry_type;

   entry_type                      head;
   entry_type                      s1_entry_ff, s2_entry_ff;
   logic [ADDR_W-1:0]              s1_acc_ff, s1_acc_in;
   logic [ADDR_W-1:0]              s2_acc_ff, s2_acc_in;
   logic [ADDR_W-1:0]              addr_ff, addr_in;
   logic                           s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic [fibp_pkg::ELEMENT_W-1:0] element_ff;
   logic                           end_ff;
   logic                           advance;

   assign head      = queue_data;
   // the whole pipe moves unless a finished item is held by the receiver
   assign advance   = !out_valid_ff || !rsp_stall;
   assign queue_pop = advance && queue_valid;

   assign s1_acc_in = ADDR_W'(head.idx[0]) * ADDR_W'(head.dim[0]) + ADDR_W'(head.idx[1]);
   assign s2_acc_in = s1_acc_ff * ADDR_W'(s1_entry_ff.dim[1]) + ADDR_W'(s1_entry_ff.idx[2]);
   assign addr_in   = s2_acc_ff * ADDR_W'(s2_entry_ff.dim[2]) + ADDR_W'(s2_entry_ff.idx[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= queue_valid;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_entry_ff <= head;
         s1_acc_ff   <= s1_acc_in;
         s2_entry_ff <= s1_entry_ff;
         s2_acc_ff   <= s2_acc_in;
         addr_ff     <= addr_in;
         element_ff  <= s2_entry_ff.element;
         end_ff      <= s2_entry_ff.last;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_element_out    = element_ff;
   assign rsp_target_address = addr_ff;
   assign rsp_block_end      = end_ff;

   `ASSERT_NEXT(a_pipe_holds, clock, reset, !advance,
      $stable(s1_valid_ff) && $stable(s2_valid_ff) && out_valid_ff,
      "pipeline moved while the result was held")

endmodule
`default_nettype wire
